[design/fsc_pkg.sv]
// shared types, constants, byte mask and modular add for the four-sum word checksum
`default_nettype none

package fsc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned WORD_BYTES = 4;

    localparam logic [WORD_W-1:0] MOD_ONES = {WORD_W{1'b1}};

    typedef logic [WORD_W-1:0] word_t;

    // word held in the input register, already masked
    typedef struct packed {
        logic  valid;
        word_t word;
        logic  last;
    } item_t;

    // the four running sums
    typedef struct packed {
        word_t first;
        word_t second;
        word_t third;
        word_t fourth;
    } sums_t;

    // add modulo 2^32-1 by end-around carry, all-ones folded to zero
    function automatic word_t mod_add(input word_t x, input word_t y);
        logic [WORD_W:0] raw;
        word_t           folded;
        begin
            raw    = {1'b0, x} + {1'b0, y};
            folded = raw[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, raw[WORD_W]};
            if (folded == MOD_ONES)
            begin
                folded = '0;
            end
            return folded;
        end
    endfunction

    // keep only the low byte lanes in use
    function automatic word_t mask_word(input word_t w, input logic [COUNT_W-1:0] nbytes);
        word_t m;
        begin
            m = '0;
            for (int i = 0; i < WORD_BYTES; i++)
            begin
                if (nbytes > COUNT_W'(i))
                begin
                    m[i*8 +: 8] = 8'hff;
                end
            end
            return w & m;
        end
    endfunction

endpackage

`default_nettype wire

[design/fsc_in_stage.sv]
// input register: masks the incoming word and holds it for the cascade
`default_nettype none

module fsc_in_stage
    import fsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire logic               drain,
    input  wire word_t              data_word,
    input  wire logic [COUNT_W-1:0] valid_bytes,
    input  wire logic               last_word,
    output item_t                   item
);

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;
    logic  last_reg;

    // occupancy: filled by a new word, emptied when the cascade takes it
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, masked on the way in
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= mask_word(data_word, valid_bytes);
            last_reg <= last_word;
        end
    end

    assign item.valid = valid_reg;
    assign item.word  = word_reg;
    assign item.last  = last_reg;

endmodule

`default_nettype wire

[design/fsc_cascade.sv]
// four cascaded modular accumulators, cleared after the last word
`default_nettype none

module fsc_cascade
    import fsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    output sums_t      sums
);

    sums_t acc_reg;
    sums_t acc_next;
    sums_t upd;

    // chained end-around-carry adds
    always_comb
    begin
        upd.first  = mod_add(acc_reg.first,  item.word);
        upd.second = mod_add(acc_reg.second, upd.first);
        upd.third  = mod_add(acc_reg.third,  upd.second);
        upd.fourth = mod_add(acc_reg.fourth, upd.third);
    end

    // hold while not advancing, clear after the final word, otherwise keep the update
    always_comb
    begin
        if (!advance)
        begin
            acc_next = acc_reg;
        end
        else if (item.last)
        begin
            acc_next = '0;
        end
        else
        begin
            acc_next = upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign sums = upd;

endmodule

`default_nettype wire

[design/four_sum_word_checksum_core.sv]
// top level of the four-sum word checksum: handshake and result register
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | data_word, valid_bytes, last_word
//  out     | output    | out_valid / out_stall | sum_first .. sum_fourth
//
// one word per cycle is taken while in_stall is low; a result is registered from the sums of its last word
// the word passes the input register, one add cascade and the result register in turn
// reset clears the accumulators and both valid flags
// a held result stalls only a last word waiting behind it; other words go on
`default_nettype none

module four_sum_word_checksum_core
    import fsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire word_t              data_word,
    input  wire logic [COUNT_W-1:0] valid_bytes,
    input  wire logic               last_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output word_t                   sum_first,
    output word_t                   sum_second,
    output word_t                   sum_third,
    output word_t                   sum_fourth
);

    item_t item;
    sums_t sums;
    logic  out_free;
    logic  advance;
    logic  in_fire;
    logic  out_valid_reg;
    logic  out_valid_next;
    sums_t out_reg;

    // flow control between the stages
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = item.valid && (!item.last || out_free);
    assign in_stall = item.valid && !advance;
    assign in_fire  = in_valid && !in_stall;

    fsc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire),
        .drain       (advance),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last_word   (last_word),
        .item        (item)
    );

    fsc_cascade u_cascade (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .sums    (sums)
    );

    // result register valid flag
    always_comb
    begin
        if (advance && item.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && item.last)
        begin
            out_reg <= sums;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sum_first  = out_reg.first;
    assign sum_second = out_reg.second;
    assign sum_third  = out_reg.third;
    assign sum_fourth = out_reg.fourth;

endmodule

`default_nettype wire

[design/fsc_checker.sv]
// port checks for the four-sum word checksum, bound to the top level
`default_nettype none

module fsc_checker
    import fsc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire word_t              data_word,
    input wire logic [COUNT_W-1:0] valid_bytes,
    input wire logic               last_word,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire word_t              sum_first,
    input wire word_t              sum_second,
    input wire word_t              sum_third,
    input wire word_t              sum_fourth
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_word) && $stable(valid_bytes)
            && $stable(last_word))
        else $error("stalled input word changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sum_first) && $stable(sum_second)
            && $stable(sum_third) && $stable(sum_fourth))
        else $error("stalled result word changed");

    // input only backs up behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // sums stay reduced modulo 2^32-1
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sum_first != MOD_ONES && sum_second != MOD_ONES
            && sum_third != MOD_ONES && sum_fourth != MOD_ONES)
        else $error("result word not reduced");

    // a result rises only if the input was not stalled or a result was already valid just before
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) == 1'b0 || $past(out_valid))
        else $error("result word appeared unprompted");

endmodule

bind four_sum_word_checksum_core fsc_checker u_fsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sum_first   (sum_first),
    .sum_second  (sum_second),
    .sum_third   (sum_third),
    .sum_fourth  (sum_fourth)
);

`default_nettype wire
